>>> sv/keyword_cipher_alphabet_builder_macros.svh
// assertion macros for the keyword cipher alphabet builder
`ifndef KEYWORD_CIPHER_ALPHABET_BUILDER_MACROS_SVH
`define KEYWORD_CIPHER_ALPHABET_BUILDER_MACROS_SVH

// same-cycle implication, checked outside reset
`define KCAB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define KCAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/kcab_pkg.sv
// shared constants for the keyword cipher alphabet builder
package kcab_pkg;

	// width of every letter and position field on the ports
	localparam int LETTER_W = 5;

endpackage

>>> sv/kcab_if.sv
// request channels: key letters in, table entries out
interface kcab_key_if;
	logic                          valid;
	logic                          ready;
	logic [kcab_pkg::LETTER_W-1:0] key_letter;
	logic                          letter_valid;
	logic                          key_end;

	modport source (output valid, key_letter, letter_valid, key_end, input ready);
	modport sink   (input valid, key_letter, letter_valid, key_end, output ready);
endinterface

interface kcab_entry_if;
	logic                          valid;
	logic                          ready;
	logic [kcab_pkg::LETTER_W-1:0] position;
	logic [kcab_pkg::LETTER_W-1:0] cipher_letter;
	logic [kcab_pkg::LETTER_W-1:0] plain_letter;
	logic                          last_entry;

	modport source (output valid, position, cipher_letter, plain_letter, last_entry,
		input ready);
	modport sink   (input valid, position, cipher_letter, plain_letter, last_entry,
		output ready);
endinterface

>>> sv/kcab_ram.sv
// generic single-port-write ram with registered read
module kcab_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/keyword_cipher_alphabet_builder.sv
// keyword cipher alphabet builder: key intake, fill walk and table read-out
// a key letter request is accepted while idle; the key-end request then adds a
// fill walk, one candidate letter per cycle (write or skip)
// read-out passes S_RD then S_OUT per entry (registered ram read), stalling while the output is full
// reset clears the seen set, the position counter and the output valid at once;
// both tables are undefined after reset and are fully rewritten before any read
`include "keyword_cipher_alphabet_builder_macros.svh"

module keyword_cipher_alphabet_builder #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic           clk,
	input  logic           arst_n,
	kcab_key_if.sink       key,
	kcab_entry_if.source   entry
);

	localparam int LW    = kcab_pkg::LETTER_W;
	localparam int IDX_W = $clog2(ALPHABET_SIZE);
	localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_RD,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   pos_q;
	logic [IDX_W-1:0]   cand_q;
	logic [ALPHABET_SIZE-1:0] seen_q;
	logic               out_valid_q;
	logic [LW-1:0]      position_q;
	logic [LW-1:0]      cipher_q;
	logic [LW-1:0]      plain_q;
	logic               last_q;

	logic [IDX_W-1:0]   key_idx;
	logic               in_range;
	logic               take;
	logic               fill_active;
	logic               fill_write;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_letter;
	logic [IDX_W-1:0]   wr_pos;
	logic [IDX_W-1:0]   rd_cipher;
	logic [IDX_W-1:0]   rd_plain;
	logic               last_pos;
	logic               out_free;

	assign key_idx   = key.key_letter[IDX_W-1:0];
	assign in_range  = {1'b0, key.key_letter} < (LW + 1)'(ALPHABET_SIZE);
	// new letter from the key: valid, in range and not yet taken
	assign take      = (state_q == S_IDLE) && key.valid && key.letter_valid && in_range
		&& !seen_q[key_idx];

	assign fill_active = (state_q == S_FILL) && (pos_q != CNT_W'(ALPHABET_SIZE));
	// candidate zero is written even if taken, which cannot arise with a full count
	assign fill_write  = fill_active && (!seen_q[cand_q] || (cand_q == '0));

	assign wr_en     = take || fill_write;
	assign wr_letter = (state_q == S_FILL) ? cand_q : key_idx;
	assign wr_pos    = pos_q[IDX_W-1:0];

	assign last_pos  = pos_q == CNT_W'(ALPHABET_SIZE - 1);
	assign out_free  = !out_valid_q || entry.ready;

	// position -> cipher letter
	kcab_ram #(
		.WIDTH (IDX_W),
		.DEPTH (ALPHABET_SIZE)
	) u_cipher_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_pos),
		.wr_data (wr_letter),
		.rd_addr (pos_q[IDX_W-1:0]),
		.rd_data (rd_cipher)
	);

	// cipher letter -> plain letter
	kcab_ram #(
		.WIDTH (IDX_W),
		.DEPTH (ALPHABET_SIZE)
	) u_inverse_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_letter),
		.wr_data (wr_pos),
		.rd_addr (pos_q[IDX_W-1:0]),
		.rd_data (rd_plain)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			cand_q      <= IDX_W'(ALPHABET_SIZE - 1);
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in S_OUT the valid flag is handled by the load below
			if (out_valid_q && entry.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						seen_q[key_idx] <= 1'b1;
						pos_q           <= pos_q + CNT_W'(1);
					end
					if (key.valid && key.key_end) begin
						cand_q  <= IDX_W'(ALPHABET_SIZE - 1);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					if (!fill_active) begin
						pos_q   <= '0;
						state_q <= S_RD;
					end else begin
						if (fill_write) begin
							seen_q[cand_q] <= 1'b1;
							pos_q          <= pos_q + CNT_W'(1);
						end
						if (cand_q != '0) begin
							cand_q <= cand_q - IDX_W'(1);
						end
					end
				end
				S_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// ram data holds while the address holds, so wait for a free slot
					if (out_free) begin
						out_valid_q <= 1'b1;
						position_q  <= LW'(pos_q);
						cipher_q    <= LW'(rd_cipher);
						plain_q     <= LW'(rd_plain);
						last_q      <= last_pos;
						if (last_pos) begin
							pos_q   <= '0;
							seen_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							pos_q   <= pos_q + CNT_W'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign key.ready           = state_q == S_IDLE;
	assign entry.valid         = out_valid_q;
	assign entry.position      = position_q;
	assign entry.cipher_letter = cipher_q;
	assign entry.plain_letter  = plain_q;
	assign entry.last_entry    = last_q;

	`KCAB_ASSERT_NOW(a_count_tracks_seen, clk, arst_n, state_q == S_IDLE,
		$countones(seen_q) == int'(pos_q), "key position count differs from seen letters")
	`KCAB_ASSERT_NOW(a_fill_has_letter, clk, arst_n, fill_active, !(&seen_q),
		"fill walk has no unused letter left")
	`KCAB_ASSERT_NOW(a_fill_in_bounds, clk, arst_n, state_q == S_FILL,
		pos_q <= CNT_W'(ALPHABET_SIZE), "fill position beyond alphabet")
	`KCAB_ASSERT_NEXT(a_entry_not_lost, clk, arst_n,
		(state_q == S_OUT) && out_valid_q && !entry.ready, state_q == S_OUT,
		"table entry loaded over a waiting entry")
	`KCAB_ASSERT_NEXT(a_clear_after_last, clk, arst_n,
		(state_q == S_OUT) && out_free && last_pos, (seen_q == '0) && (pos_q == '0),
		"state not cleared after last entry")

endmodule
